// ===== hdl/sha1_pkg.sv =====
// Shared types, constants and command struct for the SHA-1 engine.
package sha1_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_ADD,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_DATA,
    SRC_MARK,
    SRC_ZERO,
    SRC_LEN
  } src_e;

  localparam int unsigned NumWords = 5;
  localparam int unsigned NumRounds = 80;
  localparam logic [6:0] LastRound = 7'(NumRounds - 1);
  localparam logic [2:0] LastWord = 3'(NumWords - 1);
  localparam logic [5:0] LastSlot = 6'd63;
  localparam logic [5:0] LenSlot = 6'd56;
  localparam logic [7:0] PadMark = 8'h80;

  localparam logic [31:0] IvWord [NumWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef struct packed {
    logic       shift_byte;
    src_e       src;
    logic [2:0] len_sel;
    logic       count_inc;
    logic       load_work;
    logic       round_en;
    logic [6:0] round;
    logic       add_chain;
    logic       reset_msg;
    logic [2:0] out_sel;
  } dp_cmd_t;

endpackage

// ===== hdl/sha1_hash_engine_unit.sv =====
// Top level of the byte-serial SHA-1 engine: controller plus datapath.
//
// Message bytes enter one per request; a request with last_byte_i set ends the
// message (with or without a byte of its own), after which the 160-bit digest
// leaves as five 32-bit words, most significant first, and the engine starts
// over for the next message. Every 64th byte starts a block compression (80
// rounds on one shared round unit, after the round registers are loaded with
// the last byte, then a step that folds the result into the chaining value),
// during which no request is taken. At the end of a message the padding is
// shifted in one byte per cycle up to the end of the block, followed by one or
// two compressions and then five output words.
module sha1_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha1_pkg::dp_cmd_t cmd;

  sha1_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .has_byte_i   (has_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .word_index_o (word_index_o),
    .last_word_o  (last_word_o),
    .cmd_o        (cmd)
  );

  sha1_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .digest_word_o (digest_word_o)
  );

endmodule

// ===== hdl/sha1_datapath.sv =====
// Datapath: block shift register, round registers, chaining value and length count.
module sha1_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha1_pkg::dp_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output logic [31:0]       digest_word_o
);

  logic [511:0] blk_q, blk_d;
  logic [31:0]  chain_q [sha1_pkg::NumWords];
  logic [31:0]  chain_d [sha1_pkg::NumWords];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;
  logic [60:0]  byte_cnt_q, byte_cnt_d;

  logic [63:0]  len_bits;
  logic [63:0]  len_shift;
  logic [7:0]   push_byte;
  logic [31:0]  w0, w2, w8, w13, sched_x, sched_new;
  logic [31:0]  f_val, k_val, t_val;

  assign len_bits  = {byte_cnt_q, 3'b000};
  assign len_shift = len_bits >> {~cmd_i.len_sel, 3'b000};

  always_comb begin
    case (cmd_i.src)
      sha1_pkg::SRC_DATA: push_byte = data_byte_i;
      sha1_pkg::SRC_MARK: push_byte = sha1_pkg::PadMark;
      sha1_pkg::SRC_LEN:  push_byte = len_shift[7:0];
      default:            push_byte = 8'h00;
    endcase
  end

  // The oldest schedule word sits at the top of the shift register.
  assign w0  = blk_q[511:480];
  assign w2  = blk_q[447:416];
  assign w8  = blk_q[255:224];
  assign w13 = blk_q[95:64];
  assign sched_x   = w13 ^ w8 ^ w2 ^ w0;
  assign sched_new = {sched_x[30:0], sched_x[31]};

  always_comb begin
    if (cmd_i.round < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = sha1_pkg::K0;
    end else if (cmd_i.round < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_pkg::K1;
    end else if (cmd_i.round < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = sha1_pkg::K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1_pkg::K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + w0 + k_val;

  always_comb begin
    blk_d = blk_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    byte_cnt_d = byte_cnt_q;
    for (int i = 0; i < sha1_pkg::NumWords; i++) begin
      chain_d[i] = chain_q[i];
    end

    if (cmd_i.shift_byte) begin
      blk_d = {blk_q[503:0], push_byte};
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[479:0], sched_new};
    end

    if (cmd_i.load_work) begin
      a_d = chain_q[0];
      b_d = chain_q[1];
      c_d = chain_q[2];
      d_d = chain_q[3];
      e_d = chain_q[4];
    end else if (cmd_i.round_en) begin
      a_d = t_val;
      b_d = a_q;
      c_d = {b_q[1:0], b_q[31:2]};
      d_d = c_q;
      e_d = d_q;
    end

    if (cmd_i.count_inc) begin
      byte_cnt_d = byte_cnt_q + 61'd1;
    end

    if (cmd_i.add_chain) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
      chain_d[4] = chain_q[4] + e_q;
    end

    if (cmd_i.reset_msg) begin
      byte_cnt_d = '0;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_d[i] = sha1_pkg::IvWord[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_q[i] <= sha1_pkg::IvWord[i];
      end
    end else begin
      byte_cnt_q <= byte_cnt_d;
      for (int i = 0; i < sha1_pkg::NumWords; i++) begin
        chain_q[i] <= chain_d[i];
      end
    end
  end

  always_comb begin
    case (cmd_i.out_sel)
      3'd0:    digest_word_o = chain_q[0];
      3'd1:    digest_word_o = chain_q[1];
      3'd2:    digest_word_o = chain_q[2];
      3'd3:    digest_word_o = chain_q[3];
      3'd4:    digest_word_o = chain_q[4];
      default: digest_word_o = chain_q[0];
    endcase
  end

endmodule

// ===== hdl/sha1_ctrl.sv =====
// Controller: byte position, padding sequence, round counter and digest output.
module sha1_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              has_byte_i,
  input  logic              last_byte_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [2:0]        word_index_o,
  output logic              last_word_o,
  output sha1_pkg::dp_cmd_t cmd_o
);

  sha1_pkg::state_e state_q, state_d;
  logic [5:0] pos_q, pos_d;
  logic [6:0] round_q, round_d;
  logic [2:0] out_idx_q, out_idx_d;
  logic       pad_q, pad_d;
  logic       mark_q, mark_d;
  logic       len_q, len_d;
  logic       len_mode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sha1_pkg::ST_IDLE;
      pos_q     <= '0;
      round_q   <= '0;
      out_idx_q <= '0;
      pad_q     <= 1'b0;
      mark_q    <= 1'b0;
      len_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pos_q     <= pos_d;
      round_q   <= round_d;
      out_idx_q <= out_idx_d;
      pad_q     <= pad_d;
      mark_q    <= mark_d;
      len_q     <= len_d;
    end
  end

  // The length field starts at slot 56 once the pad marker is in place.
  assign len_mode = len_q | (mark_q & (pos_q == sha1_pkg::LenSlot));

  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    round_d   = round_q;
    out_idx_d = out_idx_q;
    pad_d     = pad_q;
    mark_d    = mark_q;
    len_d     = len_q;

    cmd_o.shift_byte = 1'b0;
    cmd_o.src        = sha1_pkg::SRC_DATA;
    cmd_o.len_sel    = pos_q[2:0];
    cmd_o.count_inc  = 1'b0;
    cmd_o.load_work  = 1'b0;
    cmd_o.round_en   = 1'b0;
    cmd_o.round      = round_q;
    cmd_o.add_chain  = 1'b0;
    cmd_o.reset_msg  = 1'b0;
    cmd_o.out_sel    = out_idx_q;

    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    case (state_q)
      sha1_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          pad_d = last_byte_i;
          if (last_byte_i) begin
            state_d = sha1_pkg::ST_PAD;
          end
          if (has_byte_i) begin
            cmd_o.shift_byte = 1'b1;
            cmd_o.count_inc  = 1'b1;
            pos_d = pos_q + 6'd1;
            // A full block is compressed before any padding is added.
            if (pos_q == sha1_pkg::LastSlot) begin
              cmd_o.load_work = 1'b1;
              state_d = sha1_pkg::ST_COMP;
            end
          end
        end
      end

      sha1_pkg::ST_PAD: begin
        cmd_o.shift_byte = 1'b1;
        if (!mark_q) begin
          cmd_o.src = sha1_pkg::SRC_MARK;
          mark_d = 1'b1;
        end else if (len_mode) begin
          cmd_o.src = sha1_pkg::SRC_LEN;
          len_d = 1'b1;
        end else begin
          cmd_o.src = sha1_pkg::SRC_ZERO;
        end
        pos_d = pos_q + 6'd1;
        if (pos_q == sha1_pkg::LastSlot) begin
          cmd_o.load_work = 1'b1;
          state_d = sha1_pkg::ST_COMP;
        end
      end

      sha1_pkg::ST_COMP: begin
        cmd_o.round_en = 1'b1;
        round_d = round_q + 7'd1;
        if (round_q == sha1_pkg::LastRound) begin
          round_d = '0;
          state_d = sha1_pkg::ST_ADD;
        end
      end

      sha1_pkg::ST_ADD: begin
        cmd_o.add_chain = 1'b1;
        if (len_q) begin
          state_d = sha1_pkg::ST_OUT;
        end else if (pad_q) begin
          state_d = sha1_pkg::ST_PAD;
        end else begin
          state_d = sha1_pkg::ST_IDLE;
        end
      end

      sha1_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (out_idx_q == sha1_pkg::LastWord) begin
            cmd_o.reset_msg = 1'b1;
            out_idx_d = '0;
            pos_d     = '0;
            pad_d     = 1'b0;
            mark_d    = 1'b0;
            len_d     = 1'b0;
            state_d   = sha1_pkg::ST_IDLE;
          end else begin
            out_idx_d = out_idx_q + 3'd1;
          end
        end
      end

      default: begin
        state_d = sha1_pkg::ST_IDLE;
      end
    endcase
  end

  assign word_index_o = out_idx_q;
  assign last_word_o  = (out_idx_q == sha1_pkg::LastWord);

endmodule
